// ----- rtl/core/pcc_pkg.sv -----
`default_nettype none

package pcc_pkg;

    localparam int COORD_W = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } vertex_word_t;

    typedef struct packed {
        logic convex;
        logic too_few_vertices;
    } result_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/pcc_turn.sv -----
`default_nettype none

// One turn test: registers both partial products of ax x by - ay x bx,
// then flags a negative cross product from the registered pair.
module pcc_turn #(
    parameter int EW = 17
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [EW-1:0] ax,
    input  wire logic signed [EW-1:0] ay,
    input  wire logic signed [EW-1:0] bx,
    input  wire logic signed [EW-1:0] by,
    output logic                      neg
);

    logic signed [2*EW-1:0] lhs_reg;
    logic signed [2*EW-1:0] rhs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs_reg <= ax * by;
            rhs_reg <= ay * bx;
        end
    end

    assign neg = (lhs_reg < rhs_reg);

endmodule

`default_nettype wire

// ----- rtl/core/polygon_convexity_check.sv -----
// Polygon convexity check.
// Vertices enter on the vtx channel (valid/ready), one word per vertex in
// order, with last_vertex set on the final one. For each polygon one word
// leaves on the res channel: convex is 1 when every turn, including the two
// turns at the closing edge, has a nonnegative cross product (left turn or
// collinear, counter-clockwise order); too_few_vertices is 1 when the
// polygon had fewer than three vertices. Vertices other than the last give
// no result.
// Throughput: one vertex per cycle unless an output stall holds the
// pipeline. After the last vertex is accepted, the result word passes
// the input register, operand register, product register and result
// register; each of the three turn units holds one pair of partial products.
// Only the low COORD_BITS bits of each coordinate are used, as two's
// complement.
// Reset clears the vertex count and all valid bits and sets the turn flag; the
// block then waits for the first vertex of a new polygon.
// When the receiver stalls, the result stays in the output register while
// vertices keep flowing; the pipeline holds and vtx_ready drops only when
// the next result reaches the product stage while the earlier one waits.
`default_nettype none

module polygon_convexity_check #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  vtx_valid,
    output logic                       vtx_ready,
    input  wire pcc_pkg::vertex_word_t vtx,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output pcc_pkg::result_word_t      res
);

    localparam int CW     = COORD_BITS;
    localparam int EW     = COORD_BITS + 1;
    localparam int RAW_W  = 32;

    typedef struct packed {
        logic last;
        logic few;
        logic chk_step;
        logic chk_close;
    } turn_ctl_t;

    logic adv;
    logic load_res;

    // input register
    logic                  in_valid_reg;
    pcc_pkg::vertex_word_t in_word_reg;

    // polygon state
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic signed [CW-1:0] first_x_reg, first_y_reg;
    logic signed [CW-1:0] second_x_reg, second_y_reg;
    logic signed [CW-1:0] prior_x_reg, prior_y_reg;
    logic signed [EW-1:0] edge_dx_reg, edge_dy_reg;
    logic                 all_left_reg;
    logic                 all_left_next;

    // operand stage
    logic                 op_valid_reg;
    turn_ctl_t            op_ctl_reg;
    turn_ctl_t            op_ctl_next;
    logic signed [EW-1:0] ex_reg, ey_reg, dx_reg, dy_reg;
    logic signed [EW-1:0] cx_reg, cy_reg, sx_reg, sy_reg;

    // product stage
    logic      pr_valid_reg;
    turn_ctl_t pr_ctl_reg;
    logic      neg_step, neg_close, neg_wrap;
    logic      turn_fail;

    // output register
    logic                  res_valid_reg;
    pcc_pkg::result_word_t res_word_reg;
    pcc_pkg::result_word_t res_word_next;

    logic [RAW_W-1:0]     raw_x, raw_y;
    logic signed [CW-1:0] cur_x, cur_y;
    logic signed [EW-1:0] d_x, d_y, c_x, c_y, s_x, s_y;

    // only a result leaving the product stage needs the output register
    assign load_res  = pr_valid_reg && pr_ctl_reg.last;
    assign adv       = !res_valid_reg || res_ready || !load_res;
    assign vtx_ready = adv;
    assign res_valid = res_valid_reg;
    assign res       = res_word_reg;

    // coordinate: low CW bits of the field, read as two's complement
    assign raw_x = {{(RAW_W-pcc_pkg::COORD_W){1'b0}}, in_word_reg.vertex_x};
    assign raw_y = {{(RAW_W-pcc_pkg::COORD_W){1'b0}}, in_word_reg.vertex_y};
    assign cur_x = signed'(raw_x[CW-1:0]);
    assign cur_y = signed'(raw_y[CW-1:0]);

    assign d_x = {cur_x[CW-1], cur_x} - {prior_x_reg[CW-1], prior_x_reg};
    assign d_y = {cur_y[CW-1], cur_y} - {prior_y_reg[CW-1], prior_y_reg};
    assign c_x = {first_x_reg[CW-1], first_x_reg} - {cur_x[CW-1], cur_x};
    assign c_y = {first_y_reg[CW-1], first_y_reg} - {cur_y[CW-1], cur_y};
    assign s_x = {second_x_reg[CW-1], second_x_reg} - {first_x_reg[CW-1], first_x_reg};
    assign s_y = {second_y_reg[CW-1], second_y_reg} - {first_y_reg[CW-1], first_y_reg};

    always_comb
    begin
        op_ctl_next.last      = in_word_reg.last_vertex;
        op_ctl_next.few       = (cnt_reg < 2'd2);
        op_ctl_next.chk_step  = (cnt_reg >= 2'd2);
        op_ctl_next.chk_close = in_word_reg.last_vertex && (cnt_reg >= 2'd2);

        if (in_word_reg.last_vertex)
            cnt_next = 2'd0;
        else if (cnt_reg != 2'd3)
            cnt_next = cnt_reg + 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            op_valid_reg <= 1'b0;
            pr_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else if (adv)
        begin
            in_valid_reg <= vtx_valid;
            op_valid_reg <= in_valid_reg;
            pr_valid_reg <= op_valid_reg;
            if (in_valid_reg)
                cnt_reg <= cnt_next;
        end
    end

    // payload and vertex registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_word_reg <= vtx;
            op_ctl_reg  <= op_ctl_next;
            pr_ctl_reg  <= op_ctl_reg;
            ex_reg      <= edge_dx_reg;
            ey_reg      <= edge_dy_reg;
            dx_reg      <= d_x;
            dy_reg      <= d_y;
            cx_reg      <= c_x;
            cy_reg      <= c_y;
            sx_reg      <= s_x;
            sy_reg      <= s_y;
            if (in_valid_reg)
            begin
                prior_x_reg <= cur_x;
                prior_y_reg <= cur_y;
                case (cnt_reg)
                    2'd0:
                    begin
                        first_x_reg <= cur_x;
                        first_y_reg <= cur_y;
                    end
                    2'd1:
                    begin
                        second_x_reg <= cur_x;
                        second_y_reg <= cur_y;
                        edge_dx_reg  <= d_x;
                        edge_dy_reg  <= d_y;
                    end
                    default:
                    begin
                        edge_dx_reg <= d_x;
                        edge_dy_reg <= d_y;
                    end
                endcase
            end
        end
    end

    // turn where the stored edge meets the incoming edge
    pcc_turn #(.EW(EW)) u_turn_step (
        .clk (clk),
        .en  (adv),
        .ax  (ex_reg),
        .ay  (ey_reg),
        .bx  (dx_reg),
        .by  (dy_reg),
        .neg (neg_step)
    );

    // turn from the last edge into the closing edge
    pcc_turn #(.EW(EW)) u_turn_close (
        .clk (clk),
        .en  (adv),
        .ax  (dx_reg),
        .ay  (dy_reg),
        .bx  (cx_reg),
        .by  (cy_reg),
        .neg (neg_close)
    );

    // turn from the closing edge into the first edge
    pcc_turn #(.EW(EW)) u_turn_wrap (
        .clk (clk),
        .en  (adv),
        .ax  (cx_reg),
        .ay  (cy_reg),
        .bx  (sx_reg),
        .by  (sy_reg),
        .neg (neg_wrap)
    );

    always_comb
    begin
        turn_fail = (pr_ctl_reg.chk_step && neg_step)
                 || (pr_ctl_reg.chk_close && (neg_close || neg_wrap));
        res_word_next.convex           = !pr_ctl_reg.few && all_left_reg && !turn_fail;
        res_word_next.too_few_vertices = pr_ctl_reg.few;
        if (pr_ctl_reg.last)
            all_left_next = 1'b1;
        else
            all_left_next = all_left_reg && !turn_fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            all_left_reg  <= 1'b1;
        end
        else
        begin
            if (adv && load_res)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
            if (adv && pr_valid_reg)
                all_left_reg <= all_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && load_res)
            res_word_reg <= res_word_next;
    end

    // a result word never claims both convex and too few vertices
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_word_reg.convex && res_word_reg.too_few_vertices))
        else $error("result claims convex with too few vertices");

    // a closing vertex leaving the input register restarts the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_valid_reg && in_word_reg.last_vertex) |=> (cnt_reg == 2'd0))
        else $error("vertex count not cleared after last vertex");

    // a closing vertex in the product stage yields a result and rearms the turn flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && pr_valid_reg && pr_ctl_reg.last) |=> (res_valid_reg && all_left_reg))
        else $error("last vertex did not produce a result");

endmodule

`default_nettype wire
